// ----- rtl/uv_sphere_vertex_generator_macros.svh -----
// Assertion macros shared by the sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

`define SVG_ASSERT_IMPLIES(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`define SVG_ASSERT_NEVER(lbl, a, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) else $error(msg);

`endif

// ----- rtl/svg_pkg.sv -----
// Shared types and constants of the sphere vertex generator.
package svg_pkg;

  localparam int COUNT_W  = 11;
  localparam int RADIUS_W = 16;
  localparam int DIV_W    = 43;
  localparam int PHASE_W  = 32;
  localparam int CW       = 34;
  localparam int UNIT_W   = 16;
  localparam int POS_W    = 17;
  localparam int TEX_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ATAN_LEN = 24;

  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] stack_i;
    logic [COUNT_W-1:0] sector_j;
    logic [COUNT_W-1:0] stack_n;
    logic [COUNT_W-1:0] sector_n;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic signed [PHASE_W-1:0] atan_turn(input int k);
    logic signed [PHASE_W-1:0] a;
    unique case (k)
      0: a = 32'sd536870912;
      1: a = 32'sd316933406;
      2: a = 32'sd167458907;
      3: a = 32'sd85004756;
      4: a = 32'sd42667331;
      5: a = 32'sd21354465;
      6: a = 32'sd10679838;
      7: a = 32'sd5340245;
      8: a = 32'sd2670163;
      9: a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/svg_front.sv -----
// Front stage: takes a grid point, applies count limits and index saturation.
module svg_front #(
  parameter int MAX_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [svg_pkg::COUNT_W-1:0]   stack_index,
  input  logic [svg_pkg::COUNT_W-1:0]   sector_index,
  input  logic [svg_pkg::COUNT_W-1:0]   stack_count,
  input  logic [svg_pkg::COUNT_W-1:0]   sector_count,
  input  svg_pkg::queue_status_t        qstat,
  output logic                          busy,
  output logic                          push,
  output svg_pkg::item_t                item
);
  import svg_pkg::*;

  logic  fvalid;
  logic  ready;
  logic  accept;
  logic [COUNT_W-1:0] ns;
  logic [COUNT_W-1:0] nv;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] r);
    logic [COUNT_W-1:0] e;
    if (r == '0) begin
      e = COUNT_W'(1);
    end else if (int'(r) > MAX_COUNT) begin
      e = COUNT_W'(MAX_COUNT);
    end else begin
      e = r;
    end
    return e;
  endfunction

  assign ns = eff_count(stack_count);
  assign nv = eff_count(sector_count);
  assign push = fvalid && !qstat.full;
  assign ready = !fvalid || !qstat.full;
  assign busy = !ready;
  assign accept = start && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= accept || (fvalid && qstat.full);
    end
    if (accept) begin
      item.stack_i  <= (stack_index > ns) ? ns : stack_index;
      item.sector_j <= (sector_index > nv) ? nv : sector_index;
      item.stack_n  <= ns;
      item.sector_n <= nv;
    end
  end

endmodule

// ----- rtl/svg_queue.sv -----
// Two-entry queue between the front and back stages.
module svg_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  svg_pkg::item_t         wdata,
  input  logic                   pop,
  output svg_pkg::item_t         rdata,
  output svg_pkg::queue_status_t qstat
);
  import svg_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign qstat.full = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- rtl/svg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module svg_div (
  input  logic                        clk,
  input  logic [svg_pkg::DIV_W-1:0]   num,
  input  logic [svg_pkg::COUNT_W-1:0] den,
  output logic [svg_pkg::DIV_W-1:0]   quo
);
  import svg_pkg::*;

  logic [COUNT_W-1:0] rem_q [DIV_W];
  logic [DIV_W-1:0]   sh_q  [DIV_W];
  logic [COUNT_W-1:0] den_q [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [COUNT_W-1:0] prev_rem;
    logic [DIV_W-1:0]   prev_sh;
    logic [COUNT_W-1:0] prev_den;
    logic [COUNT_W:0]   trial;
    logic               fits;
    if (k == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_sh = num;
      assign prev_den = den;
    end else begin : g_rest
      assign prev_rem = rem_q[k-1];
      assign prev_sh = sh_q[k-1];
      assign prev_den = den_q[k-1];
    end
    assign trial = {prev_rem, prev_sh[DIV_W-1]};
    assign fits = trial >= {1'b0, prev_den};
    always_ff @(posedge clk) begin
      rem_q[k] <= fits ? COUNT_W'(trial - {1'b0, prev_den}) : trial[COUNT_W-1:0];
      sh_q[k] <= {prev_sh[DIV_W-2:0], fits};
      den_q[k] <= prev_den;
    end
  end

  assign quo = sh_q[DIV_W-1];

endmodule

// ----- rtl/svg_cordic.sv -----
// Pipelined rotation CORDIC giving Q1.14 cosine and sine of a binary angle.
module svg_cordic #(
  parameter int STEPS = 16
) (
  input  logic                               clk,
  input  logic [svg_pkg::PHASE_W-1:0]        phase,
  output logic signed [svg_pkg::UNIT_W-1:0]  cosv,
  output logic signed [svg_pkg::UNIT_W-1:0]  sinv
);
  import svg_pkg::*;

  logic signed [CW-1:0]      x_q [STEPS+1];
  logic signed [CW-1:0]      y_q [STEPS+1];
  logic signed [PHASE_W-1:0] z_q [STEPS+1];
  logic [1:0]                quad_q [STEPS+1];
  logic [PHASE_W-1:0]        p;
  logic signed [CW-1:0]      c;
  logic signed [CW-1:0]      s;
  logic signed [CW-1:0]      rc;
  logic signed [CW-1:0]      rs;

  assign p = phase + 32'h2000_0000;

  always_ff @(posedge clk) begin
    quad_q[0] <= p[31:30];
    z_q[0] <= $signed({2'b00, p[29:0]}) - 32'sh2000_0000;
    x_q[0] <= INV_GAIN;
    y_q[0] <= '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      quad_q[k+1] <= quad_q[k];
      if (z_q[k] >= 0) begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - atan_turn(k);
      end else begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + atan_turn(k);
      end
    end
  end

  always_comb begin
    unique case (quad_q[STEPS])
      2'd0: begin
        c = x_q[STEPS];
        s = y_q[STEPS];
      end
      2'd1: begin
        c = -y_q[STEPS];
        s = x_q[STEPS];
      end
      2'd2: begin
        c = -x_q[STEPS];
        s = -y_q[STEPS];
      end
      default: begin
        c = y_q[STEPS];
        s = -x_q[STEPS];
      end
    endcase
    rc = (c + 34'sd32768) >>> 16;
    rs = (s + 34'sd32768) >>> 16;
  end

  function automatic logic signed [UNIT_W-1:0] clamp(input logic signed [CW-1:0] v);
    logic signed [UNIT_W-1:0] r;
    if (v > 34'sd16384) begin
      r = 16'sd16384;
    end else if (v < -34'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    cosv <= clamp(rc);
    sinv <= clamp(rs);
  end

endmodule

// ----- rtl/svg_back.sv -----
// Back stage: phase and texture division, sine and cosine, scaling and result register.
module svg_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop,
  input  svg_pkg::item_t                     item,
  input  logic [svg_pkg::RADIUS_W-1:0]       radius,
  output logic                               done,
  output logic signed [svg_pkg::POS_W-1:0]   pos_x,
  output logic signed [svg_pkg::POS_W-1:0]   pos_y,
  output logic signed [svg_pkg::POS_W-1:0]   pos_z,
  output logic signed [svg_pkg::UNIT_W-1:0]  normal_x,
  output logic signed [svg_pkg::UNIT_W-1:0]  normal_y,
  output logic signed [svg_pkg::UNIT_W-1:0]  normal_z,
  output logic [svg_pkg::TEX_W-1:0]          tex_s,
  output logic [svg_pkg::TEX_W-1:0]          tex_t
);
  import svg_pkg::*;

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int VL = DIV_W + CORDIC_LAT + 2;
  localparam int XY_W = 2*UNIT_W + 1;
  localparam int NC_W = 2*UNIT_W;
  localparam int PP_W = 3*UNIT_W + 1;

  logic [DIV_W-1:0]   num_v, num_u, num_s, num_t;
  logic [DIV_W-1:0]   q_v, q_u, q_s, q_t;
  logic [PHASE_W-1:0] ph_u;
  logic signed [UNIT_W-1:0] cu, su, cv, sv;
  logic [VL-1:0]      vl;
  logic [TEX_W-1:0]   ts_d [CORDIC_LAT];
  logic [TEX_W-1:0]   tt_d [CORDIC_LAT];

  logic signed [2*UNIT_W:0]   xy_q;
  logic signed [2*UNIT_W:0]   rsu_q;
  logic signed [2*UNIT_W-1:0] ncx_q, ncy_q;
  logic signed [UNIT_W-1:0]   cv_q, sv_q, su_q, su2_q;
  logic [TEX_W-1:0]           ts1_q, tt1_q, ts2_q, tt2_q;
  logic signed [3*UNIT_W:0]   px_q, py_q;
  logic signed [UNIT_W-1:0]   nx_q, ny_q;
  logic signed [POS_W-1:0]    pz_q;
  logic signed [2*UNIT_W-1:0] ncx_r, ncy_r;
  logic signed [2*UNIT_W:0]   rsu_r;
  logic signed [3*UNIT_W:0]   px_r, py_r;

  assign num_v = {item.sector_j, 32'd0} + DIV_W'(item.sector_n >> 1);
  assign num_u = DIV_W'({item.stack_i, 31'd0}) + DIV_W'(item.stack_n >> 1);
  assign num_s = DIV_W'({item.sector_j, 16'd0}) + DIV_W'(item.sector_n >> 1);
  assign num_t = DIV_W'({item.stack_i, 16'd0}) + DIV_W'(item.stack_n >> 1);

  svg_div u_div_v (.clk(clk), .num(num_v), .den(item.sector_n), .quo(q_v));
  svg_div u_div_u (.clk(clk), .num(num_u), .den(item.stack_n), .quo(q_u));
  svg_div u_div_s (.clk(clk), .num(num_s), .den(item.sector_n), .quo(q_s));
  svg_div u_div_t (.clk(clk), .num(num_t), .den(item.stack_n), .quo(q_t));

  assign ph_u = 32'h4000_0000 - q_u[PHASE_W-1:0];

  svg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_u (
    .clk(clk), .phase(ph_u), .cosv(cu), .sinv(su)
  );
  svg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_v (
    .clk(clk), .phase(q_v[PHASE_W-1:0]), .cosv(cv), .sinv(sv)
  );

  always_ff @(posedge clk) begin
    ts_d[0] <= q_s[TEX_W-1:0];
    tt_d[0] <= q_t[TEX_W-1:0];
    for (int k = 1; k < CORDIC_LAT; k++) begin
      ts_d[k] <= ts_d[k-1];
      tt_d[k] <= tt_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    xy_q <= XY_W'($signed({1'b0, radius})) * XY_W'(cu);
    rsu_q <= XY_W'($signed({1'b0, radius})) * XY_W'(su);
    ncx_q <= NC_W'(cu) * NC_W'(cv);
    ncy_q <= NC_W'(cu) * NC_W'(sv);
    cv_q <= cv;
    sv_q <= sv;
    su_q <= su;
    ts1_q <= ts_d[CORDIC_LAT-1];
    tt1_q <= tt_d[CORDIC_LAT-1];
  end

  assign ncx_r = (ncx_q + 32'sd8192) >>> 14;
  assign ncy_r = (ncy_q + 32'sd8192) >>> 14;
  assign rsu_r = (rsu_q + 33'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    px_q <= PP_W'(xy_q) * PP_W'(cv_q);
    py_q <= PP_W'(xy_q) * PP_W'(sv_q);
    nx_q <= ncx_r[UNIT_W-1:0];
    ny_q <= ncy_r[UNIT_W-1:0];
    pz_q <= rsu_r[POS_W-1:0];
    su2_q <= su_q;
    ts2_q <= ts1_q;
    tt2_q <= tt1_q;
  end

  assign px_r = (px_q + 49'sh800_0000) >>> 28;
  assign py_r = (py_q + 49'sh800_0000) >>> 28;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
      done <= 1'b0;
    end else begin
      vl <= {vl[VL-2:0], pop};
      done <= vl[VL-1];
    end
    pos_x <= px_r[POS_W-1:0];
    pos_y <= py_r[POS_W-1:0];
    pos_z <= pz_q;
    normal_x <= nx_q;
    normal_y <= ny_q;
    normal_z <= su2_q;
    tex_s <= ts2_q;
    tex_t <= tt2_q;
  end

endmodule

// ----- rtl/uv_sphere_vertex_generator.sv -----
// Top level of the UV sphere vertex generator.
// The block takes one grid point per clock cycle while busy is low and gives
// its vertex after the start transfer has passed the front register, the queue
// slot, the 43-stage phase divider, the CORDIC pipeline and three scaling
// stages; the result appears for one cycle with done high and the
// receiver cannot stall it.
`include "uv_sphere_vertex_generator_macros.svh"

module uv_sphere_vertex_generator #(
  parameter int MAX_COUNT = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [svg_pkg::COUNT_W-1:0]         stack_index,
  input  logic [svg_pkg::COUNT_W-1:0]         sector_index,
  input  logic                                cfg_we,
  input  logic [svg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [svg_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output logic signed [svg_pkg::POS_W-1:0]    pos_x,
  output logic signed [svg_pkg::POS_W-1:0]    pos_y,
  output logic signed [svg_pkg::POS_W-1:0]    pos_z,
  output logic signed [svg_pkg::UNIT_W-1:0]   normal_x,
  output logic signed [svg_pkg::UNIT_W-1:0]   normal_y,
  output logic signed [svg_pkg::UNIT_W-1:0]   normal_z,
  output logic [svg_pkg::TEX_W-1:0]           tex_s,
  output logic [svg_pkg::TEX_W-1:0]           tex_t
);
  import svg_pkg::*;

  localparam int LATENCY = 50 + CORDIC_STEPS;

  logic [RADIUS_W-1:0] radius;
  logic [COUNT_W-1:0]  stack_count;
  logic [COUNT_W-1:0]  sector_count;
  queue_status_t       qstat;
  item_t               f_item;
  item_t               q_item;
  logic                push;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_W'(256);
      stack_count <= COUNT_W'(18);
      sector_count <= COUNT_W'(36);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius <= cfg_data;
        REG_STACK_COUNT: stack_count <= cfg_data[COUNT_W-1:0];
        REG_SECTOR_COUNT: sector_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  svg_front #(.MAX_COUNT(MAX_COUNT)) u_front (
    .clk(clk), .rst(rst), .start(start),
    .stack_index(stack_index), .sector_index(sector_index),
    .stack_count(stack_count), .sector_count(sector_count),
    .qstat(qstat), .busy(busy), .push(push), .item(f_item)
  );

  assign pop = !qstat.empty;

  svg_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_item),
    .pop(pop), .rdata(q_item), .qstat(qstat)
  );

  svg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .pop(pop), .item(q_item), .radius(radius),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .tex_s(tex_s), .tex_t(tex_t)
  );

  `SVG_ASSERT_IMPLIES(a_latency, done, $past(start && !busy, LATENCY), "Result without a matching start transfer.")
  `SVG_ASSERT_IMPLIES(a_tex_range, done, (tex_s <= 17'd65536) && (tex_t <= 17'd65536), "Texture coordinate above one.")
  `SVG_ASSERT_IMPLIES(a_normal_range, done, (normal_z <= 16'sd16384) && (normal_z >= -16'sd16384), "Normal z outside the unit range.")
  `SVG_ASSERT_NEVER(a_queue_overrun, push && qstat.full, "Queue written while full.")

endmodule

// ----- test/uv_sphere_vertex_generator_tb.sv -----
// Self-checking testbench for the UV sphere vertex generator, with a vertex scoreboard.
module uv_sphere_vertex_generator_tb;
  import svg_pkg::*;

  localparam int LATENCY = 50 + 16;

  typedef struct {
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [UNIT_W-1:0] nx, ny, nz;
    logic [TEX_W-1:0]         ts, tt;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending[$];
    int      errors;
    int      n_radius, n_stacks, n_sectors;

    function new();
      errors = 0;
      n_radius = 256;
      n_stacks = 18;
      n_sectors = 36;
    endfunction

    static function longint fshr(longint v, int k);
      return v >>> k;
    endfunction

    static function void trig(logic [31:0] phase, output longint c14, output longint s14);
      logic [31:0] p;
      logic [1:0]  quad;
      longint z, x, y, t, c, s;
      p = phase + 32'h2000_0000;
      quad = p[31:30];
      z = longint'(p[29:0]) - 64'sh2000_0000;
      x = longint'(INV_GAIN);
      y = 0;
      for (int k = 0; k < 16; k++) begin
        if (z >= 0) begin
          t = x - fshr(y, k);
          y = y + fshr(x, k);
          z -= longint'(atan_turn(k));
        end else begin
          t = x + fshr(y, k);
          y = y - fshr(x, k);
          z += longint'(atan_turn(k));
        end
        x = t;
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      c14 = fshr(c + 32768, 16);
      s14 = fshr(s + 32768, 16);
      if (c14 > 16384) c14 = 16384;
      if (c14 < -16384) c14 = -16384;
      if (s14 > 16384) s14 = 16384;
      if (s14 < -16384) s14 = -16384;
    endfunction

    static function longint eff(int n);
      if (n == 0) return 1;
      if (n > 1024) return 1024;
      return n;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_RADIUS) n_radius = val;
      else if (idx == REG_STACK_COUNT) n_stacks = val[COUNT_W-1:0];
      else if (idx == REG_SECTOR_COUNT) n_sectors = val[COUNT_W-1:0];
    endfunction

    function void note_input(logic [COUNT_W-1:0] si, logic [COUNT_W-1:0] sj);
      longint ns, nv, i, j, cu, su, cv, sv, xy;
      logic [31:0] phu, phv;
      vertex_t e;
      ns = eff(n_stacks);
      nv = eff(n_sectors);
      i = si;
      j = sj;
      if (i > ns) i = ns;
      if (j > nv) j = nv;
      phv = 32'(((j << 32) + nv / 2) / nv);
      phu = 32'h4000_0000 - 32'(((i << 31) + ns / 2) / ns);
      trig(phu, cu, su);
      trig(phv, cv, sv);
      xy = n_radius * cu;
      e.px = POS_W'(fshr(xy * cv + (64'sd1 << 27), 28));
      e.py = POS_W'(fshr(xy * sv + (64'sd1 << 27), 28));
      e.pz = POS_W'(fshr(n_radius * su + 8192, 14));
      e.nx = UNIT_W'(fshr(cu * cv + 8192, 14));
      e.ny = UNIT_W'(fshr(cu * sv + 8192, 14));
      e.nz = UNIT_W'(su);
      e.ts = TEX_W'((j * 65536 + nv / 2) / nv);
      e.tt = TEX_W'((i * 65536 + ns / 2) / ns);
      pending = {pending, e};
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("vertex output with no transfer outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("pos_x", e.px, a.px);
      cmp("pos_y", e.py, a.py);
      cmp("pos_z", e.pz, a.pz);
      cmp("normal_x", e.nx, a.nx);
      cmp("normal_y", e.ny, a.ny);
      cmp("normal_z", e.nz, a.nz);
      cmp("tex_s", e.ts, a.ts);
      cmp("tex_t", e.tt, a.tt);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [COUNT_W-1:0] stack_index = '0, sector_index = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [UNIT_W-1:0] normal_x, normal_y, normal_z;
  logic [TEX_W-1:0] tex_s, tex_t;

  vertex_scoreboard sb = new();
  bit quiet;

  uv_sphere_vertex_generator i_dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    vertex_t a;
    if (!rst) begin
      if (start && !busy) sb.note_input(stack_index, sector_index);
      if (done) begin
        a.px = pos_x; a.py = pos_y; a.pz = pos_z;
        a.nx = normal_x; a.ny = normal_y; a.nz = normal_z;
        a.ts = tex_s; a.tt = tex_t;
        sb.check_result(a);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [COUNT_W-1:0] si, logic [COUNT_W-1:0] sj);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    stack_index <= si;
    sector_index <= sj;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] rand_index(int n);
    int r;
    r = $urandom_range(99);
    if (r < 5) return COUNT_W'($urandom);
    if (r < 10) return COUNT_W'(n);
    return COUNT_W'($urandom_range(n > 1024 ? 1024 : n));
  endfunction

  initial begin
    int cfg_r[6], cfg_st[6], cfg_se[6];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_point(0, 0);
    send_point(18, 36);
    send_point(9, 9);
    send_point(2047, 2047);
    send_point(1024, 1);
    send_point(5, 18);
    send_point(13, 27);
    drain();
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_STACK_COUNT, 16'd0);
    write_reg(REG_SECTOR_COUNT, 16'h07FF);
    write_reg(2'd3, 16'h1234);
    send_point(0, 0);
    send_point(1, 1024);
    send_point(1, 512);
    send_point(2047, 1023);
    send_point(0, 256);
    drain();
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_STACK_COUNT, 16'd1024);
    write_reg(REG_SECTOR_COUNT, 16'd1);
    send_point(512, 0);
    send_point(1024, 1);
    send_point(1025, 2);
    send_point(700, 0);
    drain();

    cfg_r = '{256, 1, 65535, 40000, 777, 300};
    cfg_st = '{18, 1, 1024, 2047, 7, 3};
    cfg_se = '{36, 1024, 1, 0, 5, 1500};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_RADIUS, CFG_DATA_W'(cfg_r[ph]));
      write_reg(REG_STACK_COUNT, CFG_DATA_W'(cfg_st[ph]));
      write_reg(REG_SECTOR_COUNT, CFG_DATA_W'(cfg_se[ph]));
      for (int n = 0; n < 325; n++) begin
        quiet = (ph == 2 && n > 50 && n < 250);
        send_point(rand_index(sb.n_stacks), rand_index(sb.n_sectors));
      end
      quiet = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/svg_pkg.sv
rtl/svg_front.sv
rtl/svg_queue.sv
rtl/svg_div.sv
rtl/svg_cordic.sv
rtl/svg_back.sv
rtl/uv_sphere_vertex_generator.sv
test/uv_sphere_vertex_generator_tb.sv
